>>> design/igaddr_pkg.sv
// shared types and constants for the im2col gather address generator
package igaddr_pkg;

	localparam int PIX_W = 24;
	localparam int DIM_W = 13;
	localparam int KER_W = 4;
	localparam int CB_W = 8;
	localparam int ADDR_W = 32;
	localparam int GEOM_W = 8;
	localparam int PAD_W = 4;
	localparam int KERNEL_MAX = 16;

	localparam int DIV_BITS = 4;
	localparam int DIV_STAGES = PIX_W / DIV_BITS;
	localparam int ADDR_STAGES = 3;
	localparam int LATENCY = DIV_STAGES + ADDR_STAGES;

	localparam int POS_W = PIX_W + 5;
	localparam int SPOS_W = POS_W + 1;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = DIM_W;

	localparam logic [CFG_IDX_W-1:0] REG_IN_HEIGHT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IN_WIDTH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GEOM_X = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GEOM_Y = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PAD_LEFT = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_PAD_TOP = 3'd6;

	localparam logic [DIM_W-1:0] DIM_RESET = 13'd1;
	localparam logic [GEOM_W-1:0] GEOM_RESET = 8'd17;

	typedef struct packed {
		logic [DIM_W-1:0]  in_height;
		logic [DIM_W-1:0]  in_width;
		logic [DIM_W-1:0]  out_width;
		logic [GEOM_W-1:0] geom_x;
		logic [GEOM_W-1:0] geom_y;
		logic [PAD_W-1:0]  pad_left;
		logic [PAD_W-1:0]  pad_top;
	} cfg_t;

	typedef struct packed {
		logic [PIX_W-1:0] pix;
		logic [KER_W-1:0] kr;
		logic [KER_W-1:0] kc;
		logic [CB_W-1:0]  cb;
	} side_t;

	typedef struct packed {
		side_t            side;
		logic [PIX_W-1:0] quo;
		logic [DIM_W-1:0] rem;
	} div_res_t;

endpackage

>>> design/im2col_gather_address.sv
// top level of the im2col gather address generator
//
// Request channel: a request beat (pixel_index, kernel_row, kernel_col,
// channel_block) is taken at each rising edge with start high and busy low.
// busy stays low, so a new request can be taken in every cycle.
// Result channel: exactly one result per request, in request order.
// done is high for one cycle with source_address and in_bounds valid;
// the receiver must take it in that cycle, it cannot hold results off.
// The pipeline has six divider stages (four quotient bits each, splitting the
// pixel index by out_width) and three address stages (stride and dilation
// products, padding and bounds check with the row multiply, final sum).
// Throughput is one request per cycle.
// Configuration: cfg_valid/cfg_ready write channel, cfg_ready always high;
// cfg_index selects in_height, in_width, out_width, geom_x, geom_y,
// pad_left, pad_top (0 to 6), other indexes are dropped. Write only while
// no request is in flight.
// Reset: arst_n clears the pipeline valid bits and loads the register
// defaults (1x1 maps, unit stride and dilation, no padding).
module im2col_gather_address (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [igaddr_pkg::PIX_W-1:0]      pixel_index,
	input  logic [igaddr_pkg::KER_W-1:0]      kernel_row,
	input  logic [igaddr_pkg::KER_W-1:0]      kernel_col,
	input  logic [igaddr_pkg::CB_W-1:0]       channel_block,
	output logic                              done,
	output logic [igaddr_pkg::ADDR_W-1:0]     source_address,
	output logic                              in_bounds,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [igaddr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [igaddr_pkg::CFG_DATA_W-1:0] cfg_data
);

	igaddr_pkg::cfg_t     cfg_q;
	igaddr_pkg::side_t    req_side;
	igaddr_pkg::div_res_t div_res;
	logic                 req_accept;
	logic                 div_vld;

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;
	assign req_accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.in_height <= igaddr_pkg::DIM_RESET;
			cfg_q.in_width <= igaddr_pkg::DIM_RESET;
			cfg_q.out_width <= igaddr_pkg::DIM_RESET;
			cfg_q.geom_x <= igaddr_pkg::GEOM_RESET;
			cfg_q.geom_y <= igaddr_pkg::GEOM_RESET;
			cfg_q.pad_left <= '0;
			cfg_q.pad_top <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				igaddr_pkg::REG_IN_HEIGHT: begin
					cfg_q.in_height <= cfg_data;
				end
				igaddr_pkg::REG_IN_WIDTH: begin
					cfg_q.in_width <= cfg_data;
				end
				igaddr_pkg::REG_OUT_WIDTH: begin
					cfg_q.out_width <= cfg_data;
				end
				igaddr_pkg::REG_GEOM_X: begin
					cfg_q.geom_x <= cfg_data[igaddr_pkg::GEOM_W-1:0];
				end
				igaddr_pkg::REG_GEOM_Y: begin
					cfg_q.geom_y <= cfg_data[igaddr_pkg::GEOM_W-1:0];
				end
				igaddr_pkg::REG_PAD_LEFT: begin
					cfg_q.pad_left <= cfg_data[igaddr_pkg::PAD_W-1:0];
				end
				igaddr_pkg::REG_PAD_TOP: begin
					cfg_q.pad_top <= cfg_data[igaddr_pkg::PAD_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign req_side.pix = pixel_index;
	assign req_side.kr = kernel_row;
	assign req_side.kc = kernel_col;
	assign req_side.cb = channel_block;

	igaddr_divider u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (req_accept),
		.in_side (req_side),
		.divisor (cfg_q.out_width),
		.out_vld (div_vld),
		.out_res (div_res)
	);

	igaddr_addr u_addr (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.in_vld         (div_vld),
		.in_res         (div_res),
		.done           (done),
		.source_address (source_address),
		.in_bounds      (in_bounds)
	);

`ifndef SYNTHESIS
	a_pad_zero_addr: assert property (@(posedge clk) disable iff (!arst_n)
		done && !in_bounds |-> source_address == '0)
		else $error("padded tap with nonzero address");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		req_accept |-> ##(igaddr_pkg::LATENCY) done)
		else $error("accepted request produced no result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(req_accept, igaddr_pkg::LATENCY))
		else $error("result without matching request");
`endif

endmodule

>>> design/igaddr_divider.sv
// pipelined restoring divider splitting the pixel index by the output width
module igaddr_divider (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_vld,
	input  igaddr_pkg::side_t            in_side,
	input  logic [igaddr_pkg::DIM_W-1:0] divisor,
	output logic                         out_vld,
	output igaddr_pkg::div_res_t         out_res
);

	logic [igaddr_pkg::DIV_STAGES-1:0] vld_s;
	igaddr_pkg::div_res_t res_s [igaddr_pkg::DIV_STAGES];
	igaddr_pkg::div_res_t res_n [igaddr_pkg::DIV_STAGES];

	always_comb begin
		igaddr_pkg::div_res_t init;
		igaddr_pkg::div_res_t prev;
		logic [igaddr_pkg::DIM_W:0]   trial;
		logic [igaddr_pkg::DIM_W-1:0] r;
		logic [igaddr_pkg::PIX_W-1:0] q;
		init.side = in_side;
		init.quo = '0;
		init.rem = '0;
		for (int i = 0; i < igaddr_pkg::DIV_STAGES; i++) begin
			prev = (i == 0) ? init : res_s[i-1];
			r = prev.rem;
			q = prev.quo;
			for (int j = 0; j < igaddr_pkg::DIV_BITS; j++) begin
				trial = {r, prev.side.pix[igaddr_pkg::PIX_W-1-i*igaddr_pkg::DIV_BITS-j]};
				if (trial >= {1'b0, divisor}) begin
					trial = trial - {1'b0, divisor};
					q = {q[igaddr_pkg::PIX_W-2:0], 1'b1};
				end else begin
					q = {q[igaddr_pkg::PIX_W-2:0], 1'b0};
				end
				r = trial[igaddr_pkg::DIM_W-1:0];
			end
			res_n[i].side = prev.side;
			res_n[i].quo = q;
			res_n[i].rem = r;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[igaddr_pkg::DIV_STAGES-2:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < igaddr_pkg::DIV_STAGES; i++) begin
			res_s[i] <= res_n[i];
		end
	end

	assign out_vld = vld_s[igaddr_pkg::DIV_STAGES-1];
	assign out_res = res_s[igaddr_pkg::DIV_STAGES-1];

endmodule

>>> design/igaddr_addr.sv
// coordinate, bounds check and vector address pipeline
module igaddr_addr (
	input  logic                          clk,
	input  logic                          arst_n,
	input  igaddr_pkg::cfg_t              cfg,
	input  logic                          in_vld,
	input  igaddr_pkg::div_res_t          in_res,
	output logic                          done,
	output logic [igaddr_pkg::ADDR_W-1:0] source_address,
	output logic                          in_bounds
);

	logic [2*igaddr_pkg::DIM_W-1:0] plane_q;

	logic                            vld_s1, vld_s2, vld_s3;
	logic [igaddr_pkg::POS_W-1:0]    ypos_s1, xpos_s1;
	logic [igaddr_pkg::ADDR_W-1:0]   cbp_s1, cbp_s2;
	logic                            kern_ok_s1;
	logic                            inside_s2;
	logic [igaddr_pkg::ADDR_W-1:0]   rowoff_s2;
	logic [igaddr_pkg::DIM_W-1:0]    col_s2;
	logic [igaddr_pkg::ADDR_W-1:0]   addr_s3;
	logic                            inb_s3;

	logic                            zero_div;
	logic [igaddr_pkg::PIX_W-1:0]    orow, ocol;
	logic [igaddr_pkg::SPOS_W-1:0]   rowd, cold;
	logic                            row_ok, col_ok;

	always_ff @(posedge clk) begin
		plane_q <= (2*igaddr_pkg::DIM_W)'(cfg.in_height) * (2*igaddr_pkg::DIM_W)'(cfg.in_width);
	end

	// stage 1: output row and column, scaled by stride and dilation; channel block offset; kernel range check
	always_comb begin
		zero_div = (cfg.out_width == '0);
		orow = zero_div ? '0 : in_res.quo;
		ocol = zero_div ? in_res.side.pix : igaddr_pkg::PIX_W'(in_res.rem);
	end

	always_ff @(posedge clk) begin
		ypos_s1 <= igaddr_pkg::POS_W'(orow) * igaddr_pkg::POS_W'(cfg.geom_y[3:0])
			+ igaddr_pkg::POS_W'(in_res.side.kr) * igaddr_pkg::POS_W'(cfg.geom_y[7:4]);
		xpos_s1 <= igaddr_pkg::POS_W'(ocol) * igaddr_pkg::POS_W'(cfg.geom_x[3:0])
			+ igaddr_pkg::POS_W'(in_res.side.kc) * igaddr_pkg::POS_W'(cfg.geom_x[7:4]);
		cbp_s1 <= igaddr_pkg::ADDR_W'(in_res.side.cb) * igaddr_pkg::ADDR_W'(plane_q);
		kern_ok_s1 <= ({1'b0, in_res.side.kr} < (igaddr_pkg::KER_W+1)'(igaddr_pkg::KERNEL_MAX))
			&& ({1'b0, in_res.side.kc} < (igaddr_pkg::KER_W+1)'(igaddr_pkg::KERNEL_MAX));
	end

	// stage 2: remove padding, bounds check, row offset
	always_comb begin
		rowd = {1'b0, ypos_s1} - igaddr_pkg::SPOS_W'(cfg.pad_top);
		cold = {1'b0, xpos_s1} - igaddr_pkg::SPOS_W'(cfg.pad_left);
		row_ok = !rowd[igaddr_pkg::SPOS_W-1]
			&& (rowd[igaddr_pkg::POS_W-1:0] < igaddr_pkg::POS_W'(cfg.in_height));
		col_ok = !cold[igaddr_pkg::SPOS_W-1]
			&& (cold[igaddr_pkg::POS_W-1:0] < igaddr_pkg::POS_W'(cfg.in_width));
	end

	always_ff @(posedge clk) begin
		inside_s2 <= kern_ok_s1 && row_ok && col_ok;
		rowoff_s2 <= igaddr_pkg::ADDR_W'(rowd[igaddr_pkg::DIM_W-1:0])
			* igaddr_pkg::ADDR_W'(cfg.in_width);
		col_s2 <= cold[igaddr_pkg::DIM_W-1:0];
		cbp_s2 <= cbp_s1;
	end

	// stage 3: final address sum
	always_ff @(posedge clk) begin
		addr_s3 <= inside_s2 ? (cbp_s2 + rowoff_s2 + igaddr_pkg::ADDR_W'(col_s2)) : '0;
		inb_s3 <= inside_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	assign done = vld_s3;
	assign source_address = addr_s3;
	assign in_bounds = inb_s3;

endmodule

>>> bench/gather_checker.sv
`timescale 1ns / 1ps
// predicts each gather tap of the address generator and compares the result beats
module gather_checker
	import igaddr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  busy,
	input  logic [PIX_W-1:0]      pixel_index,
	input  logic [KER_W-1:0]      kernel_row,
	input  logic [KER_W-1:0]      kernel_col,
	input  logic [CB_W-1:0]       channel_block,
	input  logic                  done,
	input  logic [ADDR_W-1:0]     source_address,
	input  logic                  in_bounds,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    in_flight,
	output int                    errors
);

	typedef struct {
		logic [ADDR_W-1:0] address;
		logic              in_map;
	} tap_t;

	cfg_t settings;
	tap_t expected_taps[$];
	tap_t want;

	initial errors = 0;

	function automatic tap_t predict_tap(input cfg_t c, input logic [PIX_W-1:0] pix,
			input logic [KER_W-1:0] kr, input logic [KER_W-1:0] kc,
			input logic [CB_W-1:0] cb);
		longint orow;
		longint ocol;
		longint row;
		longint col;
		longint unsigned sum;
		tap_t t;
		if (c.out_width == '0) begin
			orow = 0;
			ocol = longint'(pix);
		end else begin
			orow = longint'(pix) / longint'(c.out_width);
			ocol = longint'(pix) % longint'(c.out_width);
		end
		row = orow * longint'(c.geom_y[3:0]) + longint'(kr) * longint'(c.geom_y[7:4])
			- longint'(c.pad_top);
		col = ocol * longint'(c.geom_x[3:0]) + longint'(kc) * longint'(c.geom_x[7:4])
			- longint'(c.pad_left);
		t.in_map = kr < KERNEL_MAX && kc < KERNEL_MAX
			&& row >= 0 && row < longint'(c.in_height)
			&& col >= 0 && col < longint'(c.in_width);
		t.address = '0;
		if (t.in_map) begin
			sum = longint'(cb) * longint'(c.in_height) * longint'(c.in_width)
				+ row * longint'(c.in_width) + col;
			t.address = sum[ADDR_W-1:0];
		end
		return t;
	endfunction

	task automatic report_error(input string msg);
		errors++;
		if (errors <= 10)
			$display("%0t ns: %s", $time, msg);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settings = '{in_height: DIM_RESET, in_width: DIM_RESET, out_width: DIM_RESET,
				geom_x: GEOM_RESET, geom_y: GEOM_RESET, pad_left: '0, pad_top: '0};
			expected_taps.delete();
			in_flight <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_IN_HEIGHT: settings.in_height = cfg_data;
					REG_IN_WIDTH: settings.in_width = cfg_data;
					REG_OUT_WIDTH: settings.out_width = cfg_data;
					REG_GEOM_X: settings.geom_x = cfg_data[GEOM_W-1:0];
					REG_GEOM_Y: settings.geom_y = cfg_data[GEOM_W-1:0];
					REG_PAD_LEFT: settings.pad_left = cfg_data[PAD_W-1:0];
					REG_PAD_TOP: settings.pad_top = cfg_data[PAD_W-1:0];
					default: ;
				endcase
			end
			if (start && !busy)
				expected_taps.push_back(predict_tap(settings, pixel_index, kernel_row,
					kernel_col, channel_block));
			if (done) begin
				if (expected_taps.size() == 0) begin
					report_error($sformatf("unexpected result beat: address %h in_bounds %b",
						source_address, in_bounds));
				end else begin
					want = expected_taps.pop_front();
					if (source_address !== want.address)
						report_error($sformatf("source_address: expected %h, got %h",
							want.address, source_address));
					if (in_bounds !== want.in_map)
						report_error($sformatf("in_bounds: expected %b, got %b",
							want.in_map, in_bounds));
				end
			end
			in_flight <= expected_taps.size();
		end
	end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// stimulus and verdict for the im2col gather address generator
module testbench;
	import igaddr_pkg::*;

	localparam int PERIOD = 4;
	localparam int PHASES = 14;
	localparam int PHASE_ITEMS = 125;
	localparam int CYCLE_LIMIT = 100000;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	logic [PIX_W-1:0]      pixel_index = '0;
	logic [KER_W-1:0]      kernel_row = '0;
	logic [KER_W-1:0]      kernel_col = '0;
	logic [CB_W-1:0]       channel_block = '0;
	logic                  done;
	logic [ADDR_W-1:0]     source_address;
	logic                  in_bounds;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int in_flight;
	int errors;
	int cycles = 0;
	int idle_pct = 6;
	int out_rows;
	int kernel_span;
	bit extreme;
	cfg_t setup;

	im2col_gather_address u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.pixel_index(pixel_index),
		.kernel_row(kernel_row),
		.kernel_col(kernel_col),
		.channel_block(channel_block),
		.done(done),
		.source_address(source_address),
		.in_bounds(in_bounds),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	gather_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.pixel_index(pixel_index),
		.kernel_row(kernel_row),
		.kernel_col(kernel_col),
		.channel_block(channel_block),
		.done(done),
		.source_address(source_address),
		.in_bounds(in_bounds),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_flight(in_flight),
		.errors(errors)
	);

	always #(PERIOD / 2) clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic send_request(input logic [PIX_W-1:0] pix, input logic [KER_W-1:0] kr,
			input logic [KER_W-1:0] kc, input logic [CB_W-1:0] cb);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		pixel_index <= pix;
		kernel_row <= kr;
		kernel_col <= kc;
		channel_block <= cb;
		do @(posedge clk); while (busy);
	endtask

	// hold off new requests until every result beat has come back
	task automatic wait_drained();
		start <= 1'b0;
		do @(posedge clk); while (in_flight != 0);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic apply_settings(input cfg_t s);
		wait_drained();
		setup = s;
		write_register(REG_IN_HEIGHT, s.in_height);
		write_register(REG_IN_WIDTH, s.in_width);
		write_register(REG_UNUSED, CFG_DATA_W'($urandom));
		write_register(REG_OUT_WIDTH, s.out_width);
		write_register(REG_GEOM_X, {5'($urandom), s.geom_x});
		write_register(REG_GEOM_Y, {5'($urandom), s.geom_y});
		write_register(REG_PAD_LEFT, {9'($urandom), s.pad_left});
		write_register(REG_PAD_TOP, {9'($urandom), s.pad_top});
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [DIM_W-1:0] pick_dim();
		case ($urandom_range(0, 4))
			0: return '0;
			1: return DIM_W'(1);
			2: return '1;
			3: return DIM_W'(4096);
			default: return DIM_W'($urandom);
		endcase
	endfunction

	function automatic cfg_t random_settings(input bit wild);
		cfg_t s;
		if (wild) begin
			s.in_height = pick_dim();
			s.in_width = pick_dim();
			s.out_width = pick_dim();
			s.geom_x = GEOM_W'($urandom);
			s.geom_y = GEOM_W'($urandom);
			s.pad_left = PAD_W'($urandom);
			s.pad_top = PAD_W'($urandom);
		end else begin
			s.in_height = DIM_W'($urandom_range(1, 40));
			s.in_width = DIM_W'($urandom_range(1, 40));
			s.out_width = DIM_W'($urandom_range(1, 40));
			s.geom_x = {4'($urandom_range(1, 3)), 4'($urandom_range(1, 3))};
			s.geom_y = {4'($urandom_range(1, 3)), 4'($urandom_range(1, 3))};
			s.pad_left = PAD_W'($urandom_range(0, 3));
			s.pad_top = PAD_W'($urandom_range(0, 3));
		end
		return s;
	endfunction

	initial begin
		logic [PIX_W-1:0] pix;
		logic [KER_W-1:0] kr;
		logic [KER_W-1:0] kc;
		logic [CB_W-1:0] cb;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset settings: 1x1 map, unit stride and dilation
		send_request('0, '0, '0, '0);
		send_request('0, '0, '0, '1);
		send_request(PIX_W'(1), '0, '0, '0);
		send_request('0, KER_W'(1), '0, '0);

		apply_settings('{in_height: 6, in_width: 7, out_width: 5, geom_x: 8'h12,
			geom_y: 8'h21, pad_left: 1, pad_top: 2});
		send_request('0, '0, '0, '0);
		send_request('0, KER_W'(1), KER_W'(1), '0);
		send_request(PIX_W'(4), KER_W'(3), KER_W'(2), '1);
		send_request(PIX_W'(12), KER_W'(2), KER_W'(1), CB_W'(3));
		send_request(PIX_W'(24), '1, '1, CB_W'(17));
		send_request('1, '0, '0, '0);
		send_request(PIX_W'(6), KER_W'(1), KER_W'(3), CB_W'(128));
		send_request(PIX_W'(5), KER_W'(2), '0, '1);

		// zero divisor and zero stride and dilation nibbles
		apply_settings('{in_height: 16, in_width: 16, out_width: 0, geom_x: 8'h00,
			geom_y: 8'h00, pad_left: 0, pad_top: 0});
		send_request(PIX_W'(5), KER_W'(3), KER_W'(3), CB_W'(2));
		send_request('1, '1, '1, '1);

		// empty input map
		apply_settings('{in_height: 0, in_width: 9, out_width: 3, geom_x: 8'h11,
			geom_y: 8'h11, pad_left: 0, pad_top: 0});
		send_request('0, '0, '0, '0);
		send_request(PIX_W'(7), KER_W'(1), KER_W'(1), CB_W'(9));

		// widest maps, wrapping addresses
		apply_settings('{in_height: '1, in_width: '1, out_width: '1, geom_x: '1,
			geom_y: '1, pad_left: '1, pad_top: '1});
		send_request('1, '1, '1, '1);
		send_request(PIX_W'(8191 * 3 + 4), KER_W'(1), KER_W'(1), CB_W'(200));
		send_request('0, '0, '0, '1);
		send_request(PIX_W'(100000), KER_W'(2), KER_W'(2), '1);

		for (int p = 0; p < PHASES; p++) begin
			idle_pct = (p < 5) ? 6 : (p < 10) ? 71 : 0;
			extreme = (p % 4 == 3);
			apply_settings(random_settings(extreme));
			out_rows = $urandom_range(1, 40);
			kernel_span = $urandom_range(1, 5);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (i == PHASE_ITEMS / 2)
					wait_drained();
				if (extreme || setup.out_width == '0 || $urandom_range(0, 9) == 0)
					pix = PIX_W'($urandom);
				else
					pix = PIX_W'($urandom_range(0, setup.out_width * out_rows - 1));
				kr = ($urandom_range(0, 6) == 0) ? KER_W'($urandom)
					: KER_W'($urandom_range(0, kernel_span - 1));
				kc = ($urandom_range(0, 6) == 0) ? KER_W'($urandom)
					: KER_W'($urandom_range(0, kernel_span - 1));
				cb = ($urandom_range(0, 3) == 0) ? CB_W'($urandom)
					: CB_W'($urandom_range(0, 3));
				send_request(pix, kr, kc, cb);
			end
		end

		wait_drained();
		repeat (LATENCY + 4) @(posedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
